/* rtl/base64_stream_encoder_defines.svh */
// ---------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared checking shorthands for the encoder's concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define B64_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge out of reset.
`define B64_ASSERT_ALW(lbl, expr, msg) `B64_ASSERT_IMP(lbl, 1'b1, expr, msg)

`endif

/* rtl/b64enc_pkg.sv */
// ---------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet lookup of the Base64 stream encoder.
// ---------------------------------------------------------------------------
package b64enc_pkg;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Character job: up to four symbols produced by one input byte.
  typedef struct packed {
    logic [3:0][5:0] code;      // 6-bit symbol values
    logic [3:0]      pad;       // emit '=' instead of the symbol
    logic [1:0]      last_idx;  // index of the job's last character
    logic            eom;       // last character closes the message
  } job_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] left;
  } front_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    case (v) inside
      [6'd0:6'd25]:  c = 8'd65 + {2'b00, v};
      [6'd26:6'd51]: c = 8'd71 + {2'b00, v};
      [6'd52:6'd61]: c = {2'b00, v} - 8'd4;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

/* rtl/b64enc_front.sv */
// ---------------------------------------------------------------------------
// b64enc_front
// Accept bytes, track the group position and build character jobs.
// ---------------------------------------------------------------------------
module b64enc_front import b64enc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_i,
  input  logic [7:0]  data_i,
  input  logic        eom_i,
  input  logic        q_full_i,
  output logic        q_wr_o,
  output job_t        job_o,
  output front_stat_t stat_o
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic       acc;

  assign acc    = push_i && !q_full_i;
  assign q_wr_o = acc;
  assign stat_o = '{phase: phase_r, left: left_r};

  always_comb begin
    job_o     = '0;
    job_o.eom = eom_i;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    case (phase_r)
      2'd1: begin
        job_o.code[0] = {left_r[1:0], data_i[7:4]};
        left_nxt      = data_i[3:0];
        phase_nxt     = 2'd2;
        if (eom_i) begin
          job_o.code[1] = {data_i[3:0], 2'b00};
          job_o.pad[2]  = 1'b1;
          job_o.last_idx = 2'd2;
        end
      end
      2'd2: begin
        job_o.code[0]  = {left_r, data_i[7:6]};
        job_o.code[1]  = data_i[5:0];
        job_o.last_idx = 2'd1;
        left_nxt       = 4'd0;
        phase_nxt      = 2'd0;
      end
      default: begin
        job_o.code[0] = data_i[7:2];
        left_nxt      = {2'b00, data_i[1:0]};
        phase_nxt     = 2'd1;
        if (eom_i) begin
          job_o.code[1]  = {data_i[1:0], 4'b0000};
          job_o.pad[2]   = 1'b1;
          job_o.pad[3]   = 1'b1;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    if (eom_i) begin
      left_nxt  = 4'd0;
      phase_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* rtl/b64enc_jobq.sv */
// ---------------------------------------------------------------------------
// b64enc_jobq
// Short first-in first-out queue of character jobs.
// ---------------------------------------------------------------------------
module b64enc_jobq import b64enc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_i,
  input  job_t               wr_job_i,
  input  logic               rd_i,
  output job_t               head_o,
  output logic               full_o,
  output logic               empty_o,
  output logic [JOBQ_CW-1:0] count_o
);

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOBQ_CW-1:0] count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full_o  = (count_r == JOBQ_CW'(JOBQ_DEPTH));
  assign empty_o = (count_r == '0);
  assign count_o = count_r;
  assign head_o  = mem_r[rd_ptr_r];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job_i;
  end

endmodule

/* rtl/b64enc_back.sv */
// ---------------------------------------------------------------------------
// b64enc_back
// Walk the head job into the output register, one character per cycle while that register is empty or popped.
// ---------------------------------------------------------------------------
module b64enc_back import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_i,
  input  logic       q_empty_i,
  output logic       q_rd_o,
  output logic [1:0] idx_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] char_o,
  output logic       final_o
);

  logic       out_valid_r;
  logic [7:0] char_r;
  logic       final_r;
  logic [1:0] idx_r;
  logic       adv, take, at_last;

  assign adv     = !out_valid_r || pop_i;
  assign take    = adv && !q_empty_i;
  assign at_last = (idx_r == head_i.last_idx);
  assign q_rd_o  = take && at_last;
  assign idx_o   = idx_r;
  assign empty_o = !out_valid_r;
  assign char_o  = char_r;
  assign final_o = final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (adv) begin
      out_valid_r <= !q_empty_i;
      if (take) idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r  <= head_i.pad[idx_r] ? PAD_CHAR : b64_char(head_i.code[idx_r]);
      final_r <= head_i.eom && at_last;
    end
  end

endmodule

/* rtl/base64_stream_encoder.sv */
// ---------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_push / in_full  | in_data_byte, in_end_of_message
//  out     | output    | out_pop / out_empty| out_char, out_final_char
//
//  One byte enters per cycle while the job queue has room; the output side
//  delivers one character per cycle while it is popped, and a byte yields
//  one to four characters (about 1.33 on average, four on a last byte in
//  phase zero). The character walker sets the sustained rate.
//  Reset is synchronous and active low; it clears the group state, the
//  job queue and the output valid flag. Either side may stall on its own.
// ---------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_final_char
);

  // Front to queue: one job per accepted byte.
  job_t               wr_job;
  logic               q_wr;
  front_stat_t        fstat;

  // Queue to back: head job and its status.
  job_t               head_job;
  logic               q_full, q_empty, q_rd;
  logic [JOBQ_CW-1:0] q_count;
  logic [1:0]         back_idx;

  // Input stalls only on a full job queue.
  assign in_full = q_full;

  b64enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (in_push),
    .data_i   (in_data_byte),
    .eom_i    (in_end_of_message),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .job_o    (wr_job),
    .stat_o   (fstat)
  );

  b64enc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_i     (q_wr),
    .wr_job_i (wr_job),
    .rd_i     (q_rd),
    .head_o   (head_job),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .count_o  (q_count)
  );

  // Drain the head job; hold the output character until it is popped.
  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (head_job),
    .q_empty_i (q_empty),
    .q_rd_o    (q_rd),
    .idx_o     (back_idx),
    .pop_i     (out_pop),
    .empty_o   (out_empty),
    .char_o    (out_char),
    .final_o   (out_final_char)
  );

  // Group phase only counts bytes zero to two.
  `B64_ASSERT_ALW(a_phase_range, fstat.phase != 2'd3, "group phase reached three")
  // Queue occupancy stays within its depth.
  `B64_ASSERT_ALW(a_q_count, q_count <= JOBQ_CW'(JOBQ_DEPTH), "job queue overfilled")
  // The walker never steps past the head job's last character.
  `B64_ASSERT_IMP(a_idx_bound, !q_empty, back_idx <= head_job.last_idx,
    "character index beyond job")
  // An accepted byte leaves a job waiting.
  `B64_ASSERT_NXT(a_push_lands, in_push && !in_full, !q_empty, "accepted byte lost")

endmodule
